>>> design/hbs_pkg.sv
// Shared types and constants of the heightmap bilinear sampler.
// Used by the channel interfaces, the controller, the datapath and the top level.
package hbs_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int POS_W    = 24;
  localparam int CELL_W   = 8;
  localparam int VALUE_W  = 18;
  localparam int HEIGHT_W = 16;
  localparam int DIM_W    = 9;
  localparam int SCALE_W  = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE  = 2'd2;

  localparam logic [DIM_W-1:0]   MAP_DIM_RESET   = 9'd0;
  localparam logic [SCALE_W-1:0] INV_SCALE_RESET = 24'd65536;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    CORNER_00,
    CORNER_10,
    CORNER_01,
    CORNER_11
  } corner_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_X_LO,
    MUL_X_HI,
    MUL_Z_LO,
    MUL_Z_HI,
    MUL_TOP_A,
    MUL_TOP_B,
    MUL_BOT_A,
    MUL_BOT_B,
    MUL_SUM_A,
    MUL_SUM_B
  } mul_op_t;

  typedef struct packed {
    logic    capture;
    logic    mem_write;
    logic    mem_read;
    corner_t corner;
    mul_op_t mul_op;
    logic    clamp;
    logic    out_load;
  } hbs_cmd_t;

  typedef struct packed {
    logic small_map;
  } hbs_stat_t;

endpackage

>>> design/hbs_if.sv
// Request and result channel interfaces of the heightmap bilinear sampler.
// Depends on hbs_pkg for the payload widths.
interface hbs_in_if import hbs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [POS_W-1:0]           pos_x;
  logic [POS_W-1:0]           pos_z;
  logic [CELL_W-1:0]          cell_x;
  logic [CELL_W-1:0]          cell_z;
  logic signed [VALUE_W-1:0]  cell_value;

  modport source (output valid, op, pos_x, pos_z, cell_x, cell_z, cell_value, input ready);
  modport sink (input valid, op, pos_x, pos_z, cell_x, cell_z, cell_value, output ready);
endinterface

interface hbs_out_if import hbs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;

  modport source (output valid, height, input ready);
  modport sink (input valid, height, output ready);
endinterface

>>> design/hbs_ctrl.sv
// Sequencing controller of the heightmap bilinear sampler.
// Depends on hbs_pkg; drives the datapath through hbs_cmd_t and owns the handshakes.
module hbs_ctrl import hbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  hbs_stat_t stat,
  output hbs_cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_WRITE = 15'b000000000000010,
    S_MXL   = 15'b000000000000100,
    S_MXH   = 15'b000000000001000,
    S_MZL   = 15'b000000000010000,
    S_MZH   = 15'b000000000100000,
    S_CLAMP = 15'b000000001000000,
    S_RD00  = 15'b000000010000000,
    S_RD10  = 15'b000000100000000,
    S_RD01  = 15'b000001000000000,
    S_RD11  = 15'b000010000000000,
    S_IP0   = 15'b000100000000000,
    S_IP1   = 15'b001000000000000,
    S_IP2   = 15'b010000000000000,
    S_DONE  = 15'b100000000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd.capture   = 1'b0;
    cmd.mem_write = 1'b0;
    cmd.mem_read  = 1'b0;
    cmd.corner    = CORNER_00;
    cmd.mul_op    = MUL_NONE;
    cmd.clamp     = 1'b0;
    cmd.out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_op == OP_WRITE) begin
            state_nxt = S_WRITE;
          end else if (stat.small_map) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_MXL;
          end
        end
      end
      S_WRITE: begin
        cmd.mem_write = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_MXL: begin
        cmd.mul_op = MUL_X_LO;
        state_nxt  = S_MXH;
      end
      S_MXH: begin
        cmd.mul_op = MUL_X_HI;
        state_nxt  = S_MZL;
      end
      S_MZL: begin
        cmd.mul_op = MUL_Z_LO;
        state_nxt  = S_MZH;
      end
      S_MZH: begin
        cmd.mul_op = MUL_Z_HI;
        state_nxt  = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_RD00;
      end
      S_RD00: begin
        cmd.mem_read = 1'b1;
        cmd.corner   = CORNER_00;
        state_nxt    = S_RD10;
      end
      S_RD10: begin
        cmd.mem_read = 1'b1;
        cmd.corner   = CORNER_10;
        cmd.mul_op   = MUL_TOP_A;
        state_nxt    = S_RD01;
      end
      S_RD01: begin
        cmd.mem_read = 1'b1;
        cmd.corner   = CORNER_01;
        cmd.mul_op   = MUL_TOP_B;
        state_nxt    = S_RD11;
      end
      S_RD11: begin
        cmd.mem_read = 1'b1;
        cmd.corner   = CORNER_11;
        cmd.mul_op   = MUL_BOT_A;
        state_nxt    = S_IP0;
      end
      S_IP0: begin
        cmd.mul_op = MUL_BOT_B;
        state_nxt  = S_IP1;
      end
      S_IP1: begin
        cmd.mul_op = MUL_SUM_A;
        state_nxt  = S_IP2;
      end
      S_IP2: begin
        cmd.mul_op = MUL_SUM_B;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> design/hbs_datapath.sv
// Datapath of the heightmap bilinear sampler: configuration registers, height memory,
// shared multiplier, index clamping and the result register. Depends on hbs_pkg.
module hbs_datapath import hbs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic [POS_W-1:0]          in_pos_x,
  input  logic [POS_W-1:0]          in_pos_z,
  input  logic [CELL_W-1:0]         in_cell_x,
  input  logic [CELL_W-1:0]         in_cell_z,
  input  logic signed [VALUE_W-1:0] in_cell_value,
  input  hbs_cmd_t                  cmd,
  output hbs_stat_t                 stat,
  output logic [HEIGHT_W-1:0]       out_height
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int ZW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DXW   = (XW + 1 > DIM_W) ? XW + 1 : DIM_W;
  localparam int DZW   = (ZW + 1 > DIM_W) ? ZW + 1 : DIM_W;
  localparam int CXW   = (XW > CELL_W) ? XW : CELL_W;
  localparam int CZW   = (ZW > CELL_W) ? ZW : CELL_W;
  localparam int ACC_W = 2 * POS_W;
  localparam int MA_W  = 24;
  localparam int MB_W  = SCALE_W / 2;
  localparam int P_W   = MA_W + MB_W;
  localparam int TOP_W = HEIGHT_W + 8;
  localparam int SUM_W = 2 * HEIGHT_W;

  logic [DIM_W-1:0]   map_width_r;
  logic [DIM_W-1:0]   map_height_r;
  logic [SCALE_W-1:0] inv_scale_r;

  logic [POS_W-1:0]          pos_x_r;
  logic [POS_W-1:0]          pos_z_r;
  logic [CELL_W-1:0]         cell_x_r;
  logic [CELL_W-1:0]         cell_z_r;
  logic signed [VALUE_W-1:0] cell_value_r;

  logic [ACC_W-1:0]    gx_r;
  logic [ACC_W-1:0]    gz_r;
  logic [XW-1:0]       x0_r;
  logic [XW-1:0]       x1_r;
  logic [ZW-1:0]       z0_r;
  logic [ZW-1:0]       z1_r;
  logic [HEIGHT_W-1:0] rd_data_r;
  logic [TOP_W-1:0]    top_r;
  logic [TOP_W-1:0]    bot_r;
  logic [SUM_W-1:0]    sum_r;
  logic [HEIGHT_W-1:0] out_height_r;

  logic [HEIGHT_W-1:0] mem [DEPTH];

  logic [DXW-1:0] w_ext;
  logic [DXW-1:0] w_eff;
  logic [DZW-1:0] h_ext;
  logic [DZW-1:0] h_eff;
  logic [XW-1:0]  wm1;
  logic [ZW-1:0]  hm1;

  always_comb begin
    w_ext = DXW'(map_width_r);
    h_ext = DZW'(map_height_r);
    w_eff = (w_ext > DXW'(MAX_WIDTH)) ? DXW'(MAX_WIDTH) : w_ext;
    h_eff = (h_ext > DZW'(MAX_HEIGHT)) ? DZW'(MAX_HEIGHT) : h_ext;
    wm1   = (w_eff == '0) ? '0 : XW'(w_eff - DXW'(1));
    hm1   = (h_eff == '0) ? '0 : ZW'(h_eff - DZW'(1));
  end

  assign stat.small_map = (map_width_r < DIM_W'(2)) || (map_height_r < DIM_W'(2));

  // Write indices clamp to the map and the value saturates to the unsigned height range.
  logic [CXW-1:0]      wcx;
  logic [CZW-1:0]      wcz;
  logic [XW-1:0]       wr_x;
  logic [ZW-1:0]       wr_z;
  logic [HEIGHT_W-1:0] wr_value;

  always_comb begin
    wcx  = CXW'(cell_x_r);
    wcz  = CZW'(cell_z_r);
    wr_x = (wcx > CXW'(wm1)) ? wm1 : XW'(wcx);
    wr_z = (wcz > CZW'(hm1)) ? hm1 : ZW'(wcz);
    if (cell_value_r[VALUE_W-1]) begin
      wr_value = '0;
    end else if (cell_value_r[VALUE_W-2:HEIGHT_W] != '0) begin
      wr_value = '1;
    end else begin
      wr_value = cell_value_r[HEIGHT_W-1:0];
    end
  end

  logic [XW-1:0] rd_x;
  logic [ZW-1:0] rd_z;
  logic [AW-1:0] mem_addr;

  always_comb begin
    case (cmd.corner)
      CORNER_00: begin
        rd_x = x0_r;
        rd_z = z0_r;
      end
      CORNER_10: begin
        rd_x = x1_r;
        rd_z = z0_r;
      end
      CORNER_01: begin
        rd_x = x0_r;
        rd_z = z1_r;
      end
      CORNER_11: begin
        rd_x = x1_r;
        rd_z = z1_r;
      end
      default: begin
        rd_x = x0_r;
        rd_z = z0_r;
      end
    endcase
    if (cmd.mem_write) begin
      mem_addr = AW'(AW'(wr_z) * AW'(MAX_WIDTH)) + AW'(wr_x);
    end else begin
      mem_addr = AW'(AW'(rd_z) * AW'(MAX_WIDTH)) + AW'(rd_x);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem[mem_addr] <= wr_value;
    end
    if (cmd.mem_read) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  // Grid coordinates: integer part from bit 24 up, eight fraction bits below it.
  logic [POS_W-1:0] ix;
  logic [POS_W-1:0] iz;
  logic [7:0]       fx;
  logic [7:0]       fz;
  logic [MB_W-1:0]  fx_inv;
  logic [MB_W-1:0]  fz_inv;

  assign ix     = gx_r[ACC_W-1:ACC_W-POS_W];
  assign iz     = gz_r[ACC_W-1:ACC_W-POS_W];
  assign fx     = gx_r[23:16];
  assign fz     = gz_r[23:16];
  assign fx_inv = MB_W'(9'd256 - {1'b0, fx});
  assign fz_inv = MB_W'(9'd256 - {1'b0, fz});

  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  logic [P_W-1:0]  prod;

  always_comb begin
    case (cmd.mul_op)
      MUL_X_LO: begin
        mul_a = pos_x_r;
        mul_b = inv_scale_r[MB_W-1:0];
      end
      MUL_X_HI: begin
        mul_a = pos_x_r;
        mul_b = inv_scale_r[SCALE_W-1:MB_W];
      end
      MUL_Z_LO: begin
        mul_a = pos_z_r;
        mul_b = inv_scale_r[MB_W-1:0];
      end
      MUL_Z_HI: begin
        mul_a = pos_z_r;
        mul_b = inv_scale_r[SCALE_W-1:MB_W];
      end
      MUL_TOP_A, MUL_BOT_A: begin
        mul_a = MA_W'(rd_data_r);
        mul_b = fx_inv;
      end
      MUL_TOP_B, MUL_BOT_B: begin
        mul_a = MA_W'(rd_data_r);
        mul_b = MB_W'(fx);
      end
      MUL_SUM_A: begin
        mul_a = MA_W'(top_r);
        mul_b = fz_inv;
      end
      MUL_SUM_B: begin
        mul_a = MA_W'(bot_r);
        mul_b = MB_W'(fz);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = P_W'(mul_a) * P_W'(mul_b);

  always_ff @(posedge clk) begin
    case (cmd.mul_op)
      MUL_X_LO:  gx_r  <= ACC_W'(prod);
      MUL_X_HI:  gx_r  <= gx_r + (ACC_W'(prod) << MB_W);
      MUL_Z_LO:  gz_r  <= ACC_W'(prod);
      MUL_Z_HI:  gz_r  <= gz_r + (ACC_W'(prod) << MB_W);
      MUL_TOP_A: top_r <= prod[TOP_W-1:0];
      MUL_TOP_B: top_r <= top_r + prod[TOP_W-1:0];
      MUL_BOT_A: bot_r <= prod[TOP_W-1:0];
      MUL_BOT_B: bot_r <= bot_r + prod[TOP_W-1:0];
      MUL_SUM_A: sum_r <= prod[SUM_W-1:0];
      MUL_SUM_B: sum_r <= sum_r + prod[SUM_W-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pos_x_r      <= in_pos_x;
      pos_z_r      <= in_pos_z;
      cell_x_r     <= in_cell_x;
      cell_z_r     <= in_cell_z;
      cell_value_r <= in_cell_value;
    end
    if (cmd.clamp) begin
      x0_r <= (ix >= POS_W'(wm1)) ? wm1 : XW'(ix);
      x1_r <= (ix >= POS_W'(wm1)) ? wm1 : XW'(ix + POS_W'(1));
      z0_r <= (iz >= POS_W'(hm1)) ? hm1 : ZW'(iz);
      z1_r <= (iz >= POS_W'(hm1)) ? hm1 : ZW'(iz + POS_W'(1));
    end
  end

  // Round half up; the sum cannot pass the top of the range, the clamp is kept as a guard.
  logic [SUM_W:0]      rounded;
  logic [HEIGHT_W-1:0] result;

  always_comb begin
    rounded = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(32768);
    if (rounded[SUM_W]) begin
      result = '1;
    end else begin
      result = rounded[SUM_W-1:HEIGHT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_height_r <= stat.small_map ? '0 : result;
    end
  end

  assign out_height = out_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= MAP_DIM_RESET;
      map_height_r <= MAP_DIM_RESET;
      inv_scale_r  <= INV_SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width_r  <= cfg_data[DIM_W-1:0];
        CFG_MAP_HEIGHT: map_height_r <= cfg_data[DIM_W-1:0];
        CFG_INV_SCALE:  inv_scale_r  <= cfg_data[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/heightmap_bilinear_sampler.sv
// Top level of the heightmap bilinear sampler.
// Depends on hbs_pkg, hbs_if (channel interfaces), hbs_ctrl and hbs_datapath.

// The block holds one heightmap of MAX_WIDTH by MAX_HEIGHT cells in a single-port
// memory whose contents are undefined until written, so every cell that a sample
// touches must have been written first. A write request goes from idle through the
// write state back to idle. A sample request is through before the next is taken:
// four passes of one shared 24 by 12 bit multiplier turn both coordinates into grid
// units, a clamp state clamps the indices, the four neighboring cells are read one per
// cycle from the single memory port while the first three blend products are formed,
// three more multiplier passes finish the blend, the done state loads the result and
// the block returns to idle. When either map dimension is below two, a sample goes
// from idle straight to the done state and loads zero. A result that is still waiting
// when the next one is ready holds the controller in its last state, which adds that
// stall to the request. A finished result waits in the output register while the next
// request is accepted. The user must write configuration registers only while the
// block is idle; the block itself does not enforce this.
module heightmap_bilinear_sampler import hbs_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hbs_in_if.sink                in_ch,
  hbs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  hbs_cmd_t  cmd;
  hbs_stat_t stat;

  hbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hbs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_pos_x      (in_ch.pos_x),
    .in_pos_z      (in_ch.pos_z),
    .in_cell_x     (in_ch.cell_x),
    .in_cell_z     (in_ch.cell_z),
    .in_cell_value (in_ch.cell_value),
    .cmd           (cmd),
    .stat          (stat),
    .out_height    (out_ch.height)
  );

endmodule
